// ===== design/mccd_pkg.sv =====
// Package for the minimum coin change unit: field widths, codes,
// table entry and result types, sequencer states. No dependencies.
`default_nettype none

package mccd_pkg;

    localparam int AMT_W  = 10;
    localparam int COIN_W = 10;
    localparam int CNT_W  = 10;
    localparam int NUM_W  = 3;
    localparam int IDX_W  = 3;
    localparam int STAT_W = 2;

    localparam int DEF_MAX_AMOUNT = 1023;
    localparam int DEF_MAX_COINS  = 6;

    // request kinds
    localparam logic REQ_SOLVE = 1'b0;
    localparam logic REQ_TRACE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSOL = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_NUM_COINS = 3'd0;
    localparam logic [IDX_W-1:0] CFG_COIN_BASE = 3'd1;

    typedef struct packed {
        logic              reach;
        logic [CNT_W-1:0]  count;
        logic [COIN_W-1:0] last_coin;
    } t_entry;

    typedef struct packed {
        logic [CNT_W-1:0]  coin_count;
        logic [COIN_W-1:0] last_coin;
        logic [STAT_W-1:0] status;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZERO,
        S_ISSUE,
        S_LAST,
        S_TREAD,
        S_TDATA,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== design/mccd_if.sv =====
// Handshake interfaces for request, response and configuration words.
// Depends on mccd_pkg for field widths.
`default_nettype none

interface mccd_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [mccd_pkg::AMT_W-1:0]  amount;

    modport source (output valid, output req_type, output amount, input ready);
    modport sink   (input valid, input req_type, input amount, output ready);
endinterface

interface mccd_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mccd_pkg::CNT_W-1:0]  coin_count;
    logic [mccd_pkg::COIN_W-1:0] last_coin;
    logic [mccd_pkg::STAT_W-1:0] status;

    modport source (output valid, output coin_count, output last_coin, output status,
                    input ready);
    modport sink   (input valid, input coin_count, input last_coin, input status,
                    output ready);
endinterface

interface mccd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mccd_pkg::IDX_W-1:0]  index;
    logic [mccd_pkg::COIN_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/mccd_table.sv =====
// Count and last-coin table: one write port, one registered read port.
// Depends on mccd_pkg for the entry type.
`default_nettype none

module mccd_table #(
    parameter int DEPTH = mccd_pkg::DEF_MAX_AMOUNT + 1,
    parameter int AW    = $clog2(mccd_pkg::DEF_MAX_AMOUNT + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire mccd_pkg::t_entry i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output mccd_pkg::t_entry      o_rdata
);
    import mccd_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/min_coin_change_dp_unit.sv =====
// Minimum coin change unit: top level with sequencer, compare unit and
// coin registers. Depends on mccd_pkg, mccd_if.sv and mccd_table.
//
//   channel  | dir | carries                          | handshake
//   ---------+-----+----------------------------------+--------------------
//   i_req    | in  | req_type, amount                 | valid/ready word
//   o_rsp    | out | coin_count, last_coin, status    | valid/ready word
//   i_cfg    | in  | index, data (register write)     | valid/ready, always ready
//
// A solve of amount A walks the amounts 1 to A: each amount issues one table
// read per coin in use, counted as one when none are, through the single read
// port, then finishes with the last compare and the write in S_LAST. A trace
// reads the entry in S_TREAD and takes it in S_TDATA. A request out of range
// goes straight to S_DONE.
// Reset is synchronous; the tables are not cleared, a solve writes every
// entry that a later trace may read. The result sits in an output register
// while the block takes the next word; a stalled output holds the sequencer
// in its final state until the register frees up.
`default_nettype none

module min_coin_change_dp_unit #(
    parameter int MAX_AMOUNT = mccd_pkg::DEF_MAX_AMOUNT,
    parameter int MAX_COINS  = mccd_pkg::DEF_MAX_COINS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mccd_req_if.sink   i_req,
    mccd_rsp_if.source o_rsp,
    mccd_cfg_if.sink   i_cfg
);
    import mccd_pkg::*;

    localparam int AW  = $clog2(MAX_AMOUNT + 1);
    localparam int CIW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

    // control and configuration state
    t_state             r_state, n_state;
    logic [NUM_W-1:0]   r_num_coins;
    logic [COIN_W-1:0]  r_coin [MAX_COINS];
    logic               r_solved_valid;
    logic [AMT_W-1:0]   r_limit;
    logic               r_out_valid;
    logic               r_p_valid;

    // datapath
    logic [AMT_W-1:0]   r_target;
    logic [AMT_W-1:0]   r_i;
    logic [CIW-1:0]     r_j;
    logic               r_found;
    logic [CNT_W-1:0]   r_best;
    logic [COIN_W-1:0]  r_pick;
    logic [COIN_W-1:0]  r_p_coin;
    t_result            r_res;
    t_result            r_out;

    // combinational
    logic               in_acc;
    logic               out_free;
    logic               amt_over;
    logic               trace_bad;
    logic [NUM_W-1:0]   used;
    logic [COIN_W-1:0]  cur_coin;
    logic               issue_ok;
    logic               last_issue;
    logic [CNT_W:0]     cand;
    logic               take;
    logic               n_found;
    logic [CNT_W-1:0]   n_best;
    logic [COIN_W-1:0]  n_pick;
    logic               tbl_we;
    logic [AW-1:0]      tbl_waddr;
    t_entry             tbl_wdata;
    logic               tbl_re;
    logic [AW-1:0]      tbl_raddr;
    t_entry             tbl_rdata;

    assign in_acc    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign amt_over  = 32'(i_req.amount) > 32'(MAX_AMOUNT);
    assign trace_bad = !r_solved_valid || (i_req.amount > r_limit) || amt_over;

    // clamp the coin count to the slots that exist
    assign used = (r_num_coins > NUM_W'(MAX_COINS)) ? NUM_W'(MAX_COINS) : r_num_coins;

    assign cur_coin   = r_coin[r_j];
    assign issue_ok   = (NUM_W'(r_j) < used) && (cur_coin != '0) && (cur_coin <= r_i);
    assign last_issue = (used == '0) || (NUM_W'(r_j) == used - NUM_W'(1));

    // shared compare: strict less-than, so ties keep the earlier coin
    assign cand    = {1'b0, tbl_rdata.count} + (CNT_W + 1)'(1);
    assign take    = r_p_valid && tbl_rdata.reach && (!r_found || cand < {1'b0, r_best});
    assign n_found = r_found || take;
    assign n_best  = take ? cand[CNT_W-1:0] : r_best;
    assign n_pick  = take ? r_p_coin : r_pick;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req.req_type == REQ_SOLVE) begin
                        n_state = amt_over ? S_DONE : S_ZERO;
                    end else begin
                        n_state = trace_bad ? S_DONE : S_TREAD;
                    end
                end
            end
            S_ZERO:  n_state = (r_target == '0) ? S_DONE : S_ISSUE;
            S_ISSUE: n_state = last_issue ? S_LAST : S_ISSUE;
            S_LAST:  n_state = (r_i == r_target) ? S_DONE : S_ISSUE;
            S_TREAD: n_state = S_TDATA;
            S_TDATA: n_state = S_DONE;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // table port and handshake outputs
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = AW'(r_i);
        tbl_wdata = '{reach: n_found,
                      count: n_found ? n_best : '0,
                      last_coin: n_found ? n_pick : '0};
        tbl_re    = 1'b0;
        tbl_raddr = AW'(r_i - cur_coin);
        case (r_state)
            S_ZERO: begin
                tbl_we    = 1'b1;
                tbl_waddr = '0;
                tbl_wdata = '{reach: 1'b1, count: '0, last_coin: '0};
            end
            S_ISSUE: begin
                tbl_re = 1'b1;
            end
            S_LAST: begin
                tbl_we = 1'b1;
            end
            S_TREAD: begin
                tbl_re    = 1'b1;
                tbl_raddr = AW'(r_target);
            end
            default: begin
                tbl_we = 1'b0;
            end
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.coin_count = r_out.coin_count;
    assign o_rsp.last_coin  = r_out.last_coin;
    assign o_rsp.status     = r_out.status;

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_num_coins    <= '0;
            r_solved_valid <= 1'b0;
            r_limit        <= '0;
            r_out_valid    <= 1'b0;
            r_p_valid      <= 1'b0;
            for (int k = 0; k < MAX_COINS; k++) begin
                r_coin[k] <= COIN_W'(1);
            end
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_NUM_COINS) begin
                    r_num_coins <= i_cfg.data[NUM_W-1:0];
                end
                // slots beyond the built coin registers drop the write
                for (int k = 0; k < MAX_COINS; k++) begin
                    if (i_cfg.index == CFG_COIN_BASE + IDX_W'(k)) begin
                        r_coin[k] <= i_cfg.data;
                    end
                end
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            // the read issued this cycle is compared in the next one
            r_p_valid <= (r_state == S_ISSUE) && issue_ok;

            if (r_state == S_ZERO) begin
                r_solved_valid <= 1'b1;
                r_limit        <= r_target;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_p_coin <= cur_coin;
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_target <= i_req.amount;
                    r_res    <= '{coin_count: '0, last_coin: '0, status: ST_RANGE};
                end
            end
            S_ZERO: begin
                r_i     <= AMT_W'(1);
                r_j     <= '0;
                r_found <= 1'b0;
                r_res   <= '{coin_count: '0, last_coin: '0, status: ST_OK};
            end
            S_ISSUE: begin
                r_found <= n_found;
                r_best  <= n_best;
                r_pick  <= n_pick;
                r_j     <= r_j + CIW'(1);
            end
            S_LAST: begin
                if (n_found) begin
                    r_res <= '{coin_count: n_best, last_coin: n_pick, status: ST_OK};
                end else begin
                    r_res <= '{coin_count: '0, last_coin: '0, status: ST_NOSOL};
                end
                r_i     <= r_i + AMT_W'(1);
                r_j     <= '0;
                r_found <= 1'b0;
            end
            S_TDATA: begin
                if (tbl_rdata.reach) begin
                    r_res <= '{coin_count: tbl_rdata.count,
                               last_coin: tbl_rdata.last_coin, status: ST_OK};
                end else begin
                    r_res <= '{coin_count: '0, last_coin: '0, status: ST_NOSOL};
                end
            end
            default: begin
                r_found <= r_found;
            end
        endcase
    end

    mccd_table #(
        .DEPTH (MAX_AMOUNT + 1),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

endmodule

`default_nettype wire

// ===== design/mccd_chk.sv =====
// Port-level checker for the minimum coin change unit, bound to the top.
// Depends on mccd_pkg for status codes.
`default_nettype none

module mccd_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_req_valid,
    input wire logic                        i_req_ready,
    input wire logic                        i_rsp_valid,
    input wire logic                        i_rsp_ready,
    input wire logic [mccd_pkg::CNT_W-1:0]  i_coin_count,
    input wire logic [mccd_pkg::COIN_W-1:0] i_last_coin,
    input wire logic [mccd_pkg::STAT_W-1:0] i_status
);
    import mccd_pkg::*;

    // a pending word holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // an accepted request keeps the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status == ST_OK || i_status == ST_NOSOL
                         || i_status == ST_RANGE))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != ST_OK |-> i_coin_count == '0 && i_last_coin == '0)
        else $error("failed response carries data");

    // only amount zero has zero coins, and then no last coin
    a_ok_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_OK |-> (i_coin_count == '0) == (i_last_coin == '0))
        else $error("count and last coin disagree");

endmodule

bind min_coin_change_dp_unit mccd_chk u_mccd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_coin_count (o_rsp.coin_count),
    .i_last_coin  (o_rsp.last_coin),
    .i_status     (o_rsp.status)
);

`default_nettype wire

// ===== tb/sv/tb_min_coin_change_dp_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for min_coin_change_dp_unit: a directed script, then random
// phases of solves and trace walks, all scored against a DP predictor kept here.
// Depends on mccd_pkg, the mccd_*_if interfaces and the unit itself.

module tb_min_coin_change_dp_unit;
    import mccd_pkg::*;

    localparam int     HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int     DRAIN_CYCLES   = 40;     // quiet time after the last drain, for strays
    localparam int     PHASES         = 6;
    localparam int     PHASE_WORDS    = 12;
    localparam int     QUIET_PHASE    = 3;      // no gaps on either side
    localparam int     PRESSURE_PHASE = 4;
    localparam int     WALK_STEPS     = 10;
    localparam int     TABLE_TOP      = DEF_MAX_AMOUNT;
    // Slowest correct run: ~110 words, each a full 1023 solve over six coins
    // plus stalls, takes about 1.6 ms; allow 5x that.
    localparam longint TIMEOUT_NS     = 8_000_000;
    localparam logic [IDX_W-1:0] CFG_SPARE = 3'd7;  // no register behind it

    typedef struct packed {
        logic             is_cfg;   // 1: register write, 0: request word
        logic [IDX_W-1:0] sel;      // register index, or req_type in bit 0
        logic [AMT_W-1:0] value;    // write data, or amount
        logic             fixed;    // 1: score against want, not the predictor
        t_result          want;
    } t_script_row;

    // Directed script. Fixed answers only where they are obvious by hand.
    localparam t_script_row SCRIPT [38] = '{
        // nothing solved yet: every trace is out of range
        '{1'b0, IDX_W'(REQ_TRACE), 10'd0,    1'b1, '{10'd0,    10'd0,    ST_RANGE}},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd1023, 1'b1, '{10'd0,    10'd0,    ST_RANGE}},
        // no coins in use after reset
        '{1'b0, IDX_W'(REQ_SOLVE), 10'd0,    1'b1, '{10'd0,    10'd0,    ST_OK}},
        '{1'b0, IDX_W'(REQ_SOLVE), 10'd1023, 1'b1, '{10'd0,    10'd0,    ST_NOSOL}},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd0,    1'b1, '{10'd0,    10'd0,    ST_OK}},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd1023, 1'b1, '{10'd0,    10'd0,    ST_NOSOL}},
        '{1'b0, IDX_W'(REQ_SOLVE), 10'd5,    1'b1, '{10'd0,    10'd0,    ST_NOSOL}},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd6,    1'b1, '{10'd0,    10'd0,    ST_RANGE}},
        // coins 1, 3, 4: greedy would pick 4 for amount 6, DP finds 3 + 3
        '{1'b1, CFG_NUM_COINS,         10'd3,    1'b0, '0},
        '{1'b1, CFG_COIN_BASE,         10'd1,    1'b0, '0},
        '{1'b1, CFG_COIN_BASE + 3'd1,  10'd3,    1'b0, '0},
        '{1'b1, CFG_COIN_BASE + 3'd2,  10'd4,    1'b0, '0},
        '{1'b0, IDX_W'(REQ_SOLVE), 10'd6,    1'b0, '0},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd6,    1'b0, '0},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd3,    1'b0, '0},
        // change a coin after the solve: stored entries keep the old answer
        '{1'b1, CFG_COIN_BASE + 3'd1,  10'd1023, 1'b0, '0},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd6,    1'b0, '0},
        // count above the coin limit, a zero coin, a 2/3 tie, the widest coin,
        // and a write to an index with no register behind it
        '{1'b1, CFG_NUM_COINS,         10'd7,    1'b0, '0},
        '{1'b1, CFG_COIN_BASE,         10'd0,    1'b0, '0},
        '{1'b1, CFG_COIN_BASE + 3'd1,  10'd2,    1'b0, '0},
        '{1'b1, CFG_COIN_BASE + 3'd2,  10'd3,    1'b0, '0},
        '{1'b1, CFG_COIN_BASE + 3'd3,  10'd1023, 1'b0, '0},
        '{1'b1, CFG_COIN_BASE + 3'd4,  10'd1,    1'b0, '0},
        '{1'b1, CFG_COIN_BASE + 3'd5,  10'd7,    1'b0, '0},
        '{1'b1, CFG_SPARE,             10'd1023, 1'b0, '0},
        '{1'b0, IDX_W'(REQ_SOLVE), 10'd5,    1'b0, '0},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd5,    1'b0, '0},
        '{1'b0, IDX_W'(REQ_SOLVE), 10'd1023, 1'b1, '{10'd1,    10'd1023, ST_OK}},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd1023, 1'b1, '{10'd1,    10'd1023, ST_OK}},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd1022, 1'b0, '0},
        // single coin of 1023: only the top amount is reachable
        '{1'b1, CFG_NUM_COINS,         10'd1,    1'b0, '0},
        '{1'b1, CFG_COIN_BASE,         10'd1023, 1'b0, '0},
        '{1'b0, IDX_W'(REQ_SOLVE), 10'd1022, 1'b1, '{10'd0,    10'd0,    ST_NOSOL}},
        '{1'b0, IDX_W'(REQ_SOLVE), 10'd1023, 1'b1, '{10'd1,    10'd1023, ST_OK}},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd1,    1'b1, '{10'd0,    10'd0,    ST_NOSOL}},
        // single coin of 1: the largest possible count
        '{1'b1, CFG_COIN_BASE,         10'd1,    1'b0, '0},
        '{1'b0, IDX_W'(REQ_SOLVE), 10'd1023, 1'b1, '{10'd1023, 10'd1,    ST_OK}},
        '{1'b0, IDX_W'(REQ_TRACE), 10'd512,  1'b1, '{10'd512,  10'd1,    ST_OK}}
    };

    logic i_clk;
    logic i_rst_n;

    mccd_req_if req_bus ();
    mccd_rsp_if rsp_bus ();
    mccd_cfg_if cfg_bus ();

    min_coin_change_dp_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    // Predictor state: register shadow plus the DP tables as the unit holds them.
    logic [NUM_W-1:0]  coins_in_use = '0;
    logic [COIN_W-1:0] coin_value [0:5] = '{default: 10'd1};
    int                min_count  [0:TABLE_TOP];
    logic [COIN_W-1:0] final_coin [0:TABLE_TOP];
    bit                reachable  [0:TABLE_TOP];
    int                solved_hi  = 0;
    bit                solved_ok  = 1'b0;

    t_result pending_answers [$];   // answers owed by the unit, oldest first
    t_result due;

    bit idle_on    = 1'b1;  // random gaps on both sides
    bit hold_rsp   = 1'b0;  // ask the receiver for one long hold-off
    bit cfg_open   = 1'b0;  // config valid still high from the last write
    bit need_drain = 1'b0;  // request words sent since the last drain

    int mismatches      = 0;
    int results_checked = 0;
    int solves_sent     = 0;
    int traces_sent     = 0;
    int writes_done     = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("min_coin_change_dp_unit regression: fail");
        $finish;
    end

    // Work out the answer to one request word and advance the tables.
    // The amount field cannot exceed the table size, so the beyond-table
    // solve case never arises at this width.
    function automatic t_result coin_change_answer(input logic kind,
                                                   input logic [AMT_W-1:0] amt);
        t_result           ans;
        int                used, a, j, c, best;
        bit                found;
        logic [COIN_W-1:0] pick;
        ans = '{coin_count: '0, last_coin: '0, status: ST_RANGE};
        if (kind == REQ_SOLVE) begin
            // a count above the coin limit uses every register
            used = (int'(coins_in_use) > DEF_MAX_COINS) ? DEF_MAX_COINS
                                                       : int'(coins_in_use);
            reachable[0]  = 1'b1;
            min_count[0]  = 0;
            final_coin[0] = '0;
            for (a = 1; a <= int'(amt); a++) begin
                found = 1'b0;
                best  = 0;
                pick  = '0;
                for (j = 0; j < used; j++) begin
                    c = int'(coin_value[j]);
                    // skip zero coins, coins too big, and unreachable remainders
                    if (c == 0 || c > a || !reachable[a - c])
                        continue;
                    // strict compare: on a tie the earlier register stays
                    if (!found || min_count[a - c] + 1 < best) begin
                        found = 1'b1;
                        best  = min_count[a - c] + 1;
                        pick  = coin_value[j];
                    end
                end
                reachable[a]  = found;
                min_count[a]  = found ? best : 0;
                final_coin[a] = pick;
            end
            solved_hi = int'(amt);
            solved_ok = 1'b1;
        end else if (!solved_ok || int'(amt) > solved_hi) begin
            return ans;
        end
        if (reachable[amt])
            ans = '{coin_count: CNT_W'(min_count[amt]), last_coin: final_coin[amt],
                    status: ST_OK};
        else
            ans = '{coin_count: '0, last_coin: '0, status: ST_NOSOL};
        return ans;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Offer one request word and hold it until taken. Valid stays high on
    // return so a following word goes out back to back; whoever waits next
    // drops it.
    task automatic issue_request(input logic kind, input logic [AMT_W-1:0] amt,
                                 input logic fixed, input t_result want);
        int      gap;
        t_result predicted;
        gap = pick_gap();
        if (cfg_open) begin
            cfg_bus.valid <= 1'b0;
            cfg_open = 1'b0;
        end
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.amount   <= amt;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        predicted = coin_change_answer(kind, amt);
        pending_answers.insert(pending_answers.size(), fixed ? want : predicted);
        need_drain = 1'b1;
        if (kind == REQ_SOLVE)
            solves_sent++;
        else
            traces_sent++;
    endtask

    // Write one register; valid stays high for a following write.
    task automatic write_register(input logic [IDX_W-1:0] idx,
                                  input logic [COIN_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        cfg_open = 1'b1;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        if (idx == CFG_NUM_COINS)
            coins_in_use = data[NUM_W-1:0];
        else if (idx >= CFG_COIN_BASE && idx < CFG_COIN_BASE + DEF_MAX_COINS)
            coin_value[idx - CFG_COIN_BASE] = data;
        writes_done++;
    endtask

    // Drop request valid and wait until every owed answer is back.
    task automatic drain_answers();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
        need_drain = 1'b0;
    endtask

    // Receiver pacing: random stalls, one long hold-off on request, none
    // at all in the quiet phase.
    initial begin : rsp_pacing
        int stall_left;
        stall_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rsp) begin
                hold_rsp = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!idle_on) begin
                rsp_bus.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Score every accepted result word against the oldest owed answer.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected word count %0d last %0d status %0d", $time,
                         rsp_bus.coin_count, rsp_bus.last_coin, rsp_bus.status);
                mismatches++;
            end else begin
                due = pending_answers.pop_front();
                results_checked++;
                if (rsp_bus.coin_count !== due.coin_count) begin
                    $display("%0t: coin_count expected %0d got %0d", $time,
                             due.coin_count, rsp_bus.coin_count);
                    mismatches++;
                end
                if (rsp_bus.last_coin !== due.last_coin) begin
                    $display("%0t: last_coin expected %0d got %0d", $time,
                             due.last_coin, rsp_bus.last_coin);
                    mismatches++;
                end
                if (rsp_bus.status !== due.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             due.status, rsp_bus.status);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int                p, r, j, sent, steps, rem, pick;
        logic [AMT_W-1:0]  amt;
        logic [COIN_W-1:0] coin;
        logic [NUM_W-1:0]  num;

        // Hold reset with every input at a known value.
        i_rst_n          <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= REQ_SOLVE;
        req_bus.amount   <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= CFG_NUM_COINS;
        cfg_bus.data     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed script; drain before each group of writes so
        // registers only change while the unit is idle.
        for (r = 0; r < $size(SCRIPT); r++) begin
            if (SCRIPT[r].is_cfg) begin
                if (need_drain)
                    drain_answers();
                write_register(SCRIPT[r].sel, SCRIPT[r].value);
            end else begin
                issue_request(SCRIPT[r].sel[0], SCRIPT[r].value, SCRIPT[r].fixed,
                              SCRIPT[r].want);
            end
        end

        // Random phases: new coin set, then mostly a solve followed by a
        // trace walk down the stored last coins, with some stray traces.
        for (p = 0; p < PHASES; p++) begin
            if (need_drain)
                drain_answers();
            idle_on = (p != QUIET_PHASE);
            if (p == 0) begin
                // a familiar six-coin set first
                write_register(CFG_NUM_COINS, 10'd6);
                write_register(CFG_COIN_BASE,         10'd1);
                write_register(CFG_COIN_BASE + 3'd1,  10'd5);
                write_register(CFG_COIN_BASE + 3'd2,  10'd10);
                write_register(CFG_COIN_BASE + 3'd3,  10'd25);
                write_register(CFG_COIN_BASE + 3'd4,  10'd50);
                write_register(CFG_COIN_BASE + 3'd5,  10'd100);
            end else begin
                num = ($urandom_range(0, 3) == 0) ? NUM_W'($urandom_range(0, 7))
                                                  : NUM_W'($urandom_range(2, 6));
                // upper data bits are junk for the count register
                write_register(CFG_NUM_COINS, {7'($urandom), num});
                for (j = 0; j < 6; j++) begin
                    case ($urandom_range(0, 9))
                        0:       coin = '0;
                        1:       coin = COIN_W'($urandom_range(512, 1023));
                        default: coin = COIN_W'($urandom_range(1, 24));
                    endcase
                    write_register(CFG_COIN_BASE + IDX_W'(j), coin);
                end
                if (p % 2 == 1)
                    write_register(CFG_SPARE, COIN_W'($urandom));
            end

            sent = 0;
            if (p == PRESSURE_PHASE) begin
                // Solve, then hold the receiver off while a burst of traces
                // keeps coming, so the output register fills and input stalls.
                issue_request(REQ_SOLVE, AMT_W'($urandom_range(8, 40)), 1'b0, '0);
                hold_rsp = 1'b1;
                idle_on  = 1'b0;
                for (j = 0; j < 8; j++)
                    issue_request(REQ_TRACE, AMT_W'($urandom_range(0, solved_hi)),
                                  1'b0, '0);
                idle_on = 1'b1;
                sent    = 9;
            end

            while (sent < PHASE_WORDS) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    // small amounts keep solves short; a few go wider
                    amt = ($urandom_range(0, 7) == 0) ? AMT_W'($urandom_range(61, 300))
                                                      : AMT_W'($urandom_range(0, 60));
                    issue_request(REQ_SOLVE, amt, 1'b0, '0);
                    sent++;
                    rem   = int'(amt);
                    steps = 0;
                    while (rem > 0 && steps < WALK_STEPS) begin
                        issue_request(REQ_TRACE, AMT_W'(rem), 1'b0, '0);
                        sent++;
                        steps++;
                        if (!reachable[rem])
                            break;
                        rem -= int'(final_coin[rem]);
                    end
                end else if (pick < 8) begin
                    // trace inside the solved range, possibly with stale coins
                    amt = solved_ok ? AMT_W'($urandom_range(0, solved_hi))
                                    : AMT_W'($urandom_range(0, TABLE_TOP));
                    issue_request(REQ_TRACE, amt, 1'b0, '0);
                    sent++;
                end else if (pick == 8) begin
                    // trace past the solved range
                    amt = (solved_ok && solved_hi < TABLE_TOP)
                        ? AMT_W'($urandom_range(solved_hi + 1, TABLE_TOP))
                        : AMT_W'($urandom_range(0, TABLE_TOP));
                    issue_request(REQ_TRACE, amt, 1'b0, '0);
                    sent++;
                end else begin
                    // noise: any kind, any amount
                    issue_request(1'($urandom_range(0, 1)),
                                  AMT_W'($urandom_range(0, TABLE_TOP)), 1'b0, '0);
                    sent++;
                end
            end
        end

        // Wait out the last answers, then a few more cycles for strays.
        drain_answers();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d solves, %0d traces and %0d register writes over %0d phases",
                 solves_sent, traces_sent, writes_done, PHASES + 1);
        $display("%0d result words checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("min_coin_change_dp_unit regression: pass");
        else
            $display("min_coin_change_dp_unit regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mccd_pkg.sv
design/mccd_if.sv
design/mccd_table.sv
design/min_coin_change_dp_unit.sv
design/mccd_chk.sv
tb/sv/tb_min_coin_change_dp_unit.sv
